@@ sv/bbc_pkg.sv @@
// Package: shared types, codes and widths of the block buffer cache tag manager.
`timescale 1ns / 1ps

package bbc_pkg;

   localparam int MODE_W  = 3;
   localparam int BLK_W   = 48;
   localparam int IDX_W   = 6;
   localparam int CMD_W   = 2;
   localparam int ERR_W   = 2;
   localparam int CFG_W   = 4;

   // request modes
   localparam logic [MODE_W-1:0] MODE_GET_READ   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_GET_NOREAD = 3'd1;
   localparam logic [MODE_W-1:0] MODE_GET_CLEAR  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ_AHEAD = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RELEASE    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_MARK_DIRTY = 3'd5;
   localparam logic [MODE_W-1:0] MODE_INVALIDATE = 3'd6;

   // device commands
   localparam logic [CMD_W-1:0] DEV_NONE  = 2'd0;
   localparam logic [CMD_W-1:0] DEV_READ  = 2'd1;
   localparam logic [CMD_W-1:0] DEV_WRITE = 2'd2;
   localparam logic [CMD_W-1:0] DEV_CLEAR = 2'd3;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_BUSY    = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NO_FREE = 2'd2;
   localparam logic [ERR_W-1:0] ERR_NOT_USE = 2'd3;

   // datapath operations
   typedef logic [4:0] dp_op_type;
   localparam dp_op_type OP_NONE      = 5'd0;
   localparam dp_op_type OP_CLR       = 5'd1;
   localparam dp_op_type OP_LOAD      = 5'd2;
   localparam dp_op_type OP_SCAN      = 5'd3;
   localparam dp_op_type OP_LNK_RD    = 5'd4;
   localparam dp_op_type OP_UNLINK    = 5'd5;
   localparam dp_op_type OP_USE       = 5'd6;
   localparam dp_op_type OP_PUSHH_INV = 5'd7;
   localparam dp_op_type OP_POP_RD    = 5'd8;
   localparam dp_op_type OP_ALLOC     = 5'd9;
   localparam dp_op_type OP_NEXT_T    = 5'd10;
   localparam dp_op_type OP_RB        = 5'd11;
   localparam dp_op_type OP_RA_REL    = 5'd12;
   localparam dp_op_type OP_RD_IDX    = 5'd13;
   localparam dp_op_type OP_CAP       = 5'd14;
   localparam dp_op_type OP_REL       = 5'd15;
   localparam dp_op_type OP_DIRTY     = 5'd16;

   // result kinds
   typedef logic [3:0] emit_kind_type;
   localparam emit_kind_type EK_HIT_BUSY = 4'd0;
   localparam emit_kind_type EK_HIT      = 4'd1;
   localparam emit_kind_type EK_MISS     = 4'd2;
   localparam emit_kind_type EK_NO_FREE  = 4'd3;
   localparam emit_kind_type EK_ZERO     = 4'd4;
   localparam emit_kind_type EK_REL_BAD  = 4'd5;
   localparam emit_kind_type EK_REL_WB   = 4'd6;
   localparam emit_kind_type EK_IDX      = 4'd7;
   localparam emit_kind_type EK_RA       = 4'd8;

   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic             in_use;
      logic [BLK_W-1:0] tag;
   } meta_type;

   typedef struct packed {
      dp_op_type     op;
      logic          emit_en;
      emit_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic clr_last;
      logic scan_done;
      logic found;
      logic meta_in_use;
      logic meta_dirty;
      logic idx_in_range;
      logic count_zero;
      logic t_first;
      logic t_last;
      logic n_zero;
      logic ra_emit_last;
      logic ra_rel_done;
      logic out_free;
   } dp_status_type;

endpackage

@@ sv/bbc_if.sv @@
// Interfaces: request and response channels with valid/ready handshake.
`timescale 1ns / 1ps

interface bbc_req_if;
   logic                         valid;
   logic                         ready;
   logic [bbc_pkg::MODE_W-1:0]   mode;
   logic [bbc_pkg::BLK_W-1:0]    block_number;
   logic [bbc_pkg::IDX_W-1:0]    buffer_index;
   modport source (output valid, mode, block_number, buffer_index, input ready);
   modport sink (input valid, mode, block_number, buffer_index, output ready);
endinterface

interface bbc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bbc_pkg::IDX_W-1:0]    result_buffer;
   logic                         was_hit;
   logic [bbc_pkg::CMD_W-1:0]    device_command;
   logic [bbc_pkg::BLK_W-1:0]    device_block;
   logic [bbc_pkg::ERR_W-1:0]    error_code;
   logic                         last;
   modport source (output valid, result_buffer, was_hit, device_command, device_block,
                   error_code, last, input ready);
   modport sink (input valid, result_buffer, was_hit, device_command, device_block,
                 error_code, last, output ready);
endinterface

@@ sv/block_buffer_cache_lru_top.sv @@
// Top level: block buffer cache tag manager with least-recently-released replacement.
`timescale 1ns / 1ps

// Tracks tags and valid/dirty/in-use marks of NUM_BUFFERS buffers plus an
// ordered free queue, and answers get, read-ahead, release, mark-dirty and
// invalidate items with one or more result items (last marks the final one);
// device reads, writebacks and clears are only reported, never performed.
// One item is worked at a time. Block lookup scans the tag memory one entry
// per cycle through its single read port and stops early on a hit; a
// read-ahead looks up each of its count blocks in turn. Each result waits
// while the output register is still full. The free queue is a doubly
// linked list held in two memories. After reset a clearing pass over all
// NUM_BUFFERS entries initializes the marks and the list, with req_ready
// low; csr writes are taken at any time and the read-ahead count is
// clamped to 1..MAX_READ_AHEAD when an item starts.

module block_buffer_cache_lru_top #(
   parameter int NUM_BUFFERS    = 64,
   parameter int MAX_READ_AHEAD = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   bbc_req_if.sink                    req_chan,
   bbc_rsp_if.source                  rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [bbc_pkg::CFG_W-1:0]  csr_write_data
);

   bbc_pkg::dp_cmd_type    cmd;
   bbc_pkg::dp_status_type status;

   // sequencing
   bbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, free list and result register
   bbc_datapath #(
      .NUM_BUFFERS    (NUM_BUFFERS),
      .MAX_READ_AHEAD (MAX_READ_AHEAD)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_chan.mode),
      .req_block_number   (req_chan.block_number),
      .req_buffer_index   (req_chan.buffer_index),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_result_buffer  (rsp_chan.result_buffer),
      .rsp_was_hit        (rsp_chan.was_hit),
      .rsp_device_command (rsp_chan.device_command),
      .rsp_device_block   (rsp_chan.device_block),
      .rsp_error_code     (rsp_chan.error_code),
      .rsp_last           (rsp_chan.last)
   );

endmodule

@@ sv/bbc_datapath.sv @@
// Datapath: tag/mark memory, free list as linked memories, read-ahead lists, result register.
`timescale 1ns / 1ps

module bbc_datapath #(
   parameter int NUM_BUFFERS    = 64,
   parameter int MAX_READ_AHEAD = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bbc_pkg::dp_cmd_type         cmd,
   output bbc_pkg::dp_status_type      status,
   input  logic [bbc_pkg::MODE_W-1:0]  req_mode,
   input  logic [bbc_pkg::BLK_W-1:0]   req_block_number,
   input  logic [bbc_pkg::IDX_W-1:0]   req_buffer_index,
   input  logic                        csr_write_enable,
   input  logic [bbc_pkg::CFG_W-1:0]   csr_write_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bbc_pkg::IDX_W-1:0]   rsp_result_buffer,
   output logic                        rsp_was_hit,
   output logic [bbc_pkg::CMD_W-1:0]   rsp_device_command,
   output logic [bbc_pkg::BLK_W-1:0]   rsp_device_block,
   output logic [bbc_pkg::ERR_W-1:0]   rsp_error_code,
   output logic                        rsp_last
);

   localparam int IW  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int CW  = $clog2(NUM_BUFFERS + 1);
   localparam int XW  = 11;
   localparam int RAW = (MAX_READ_AHEAD > 1) ? $clog2(MAX_READ_AHEAD) : 1;
   localparam int NW  = $clog2(MAX_READ_AHEAD + 1);
   localparam int BW  = bbc_pkg::BLK_W;

   // memories
   bbc_pkg::meta_type meta_mem [NUM_BUFFERS];
   logic [IW-1:0]     next_mem [NUM_BUFFERS];
   logic [IW-1:0]     prev_mem [NUM_BUFFERS];

   bbc_pkg::meta_type meta_q_ff;
   logic [IW-1:0]     lnext_q_ff, lprev_q_ff;

   // control registers
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] clr_ff;
   logic [bbc_pkg::CFG_W-1:0] cfg_ff;

   // item registers
   logic [bbc_pkg::MODE_W-1:0] mode_ff;
   logic [BW-1:0]              blk_ff, cur_blk_ff;
   logic [bbc_pkg::IDX_W-1:0]  idx_ff;
   logic [IW-1:0]              buf_ff;
   bbc_pkg::meta_type          meta_ff;

   // scan
   logic [CW-1:0] scan_cnt_ff;
   logic          pend_ff, done_ff, found_ff;
   logic [IW-1:0] pend_idx_ff;

   // read-ahead lists: buffer, its block and its metadata before allocation
   logic [IW-1:0]     bufs_ff [MAX_READ_AHEAD];
   logic [BW-1:0]     blks_ff [MAX_READ_AHEAD];
   bbc_pkg::meta_type old_ff  [MAX_READ_AHEAD];
   logic [NW-1:0]     n_ff, t_ff, e_ff, r_ff, total_ff;

   // result register
   logic                       rsp_valid_ff;
   logic [bbc_pkg::IDX_W-1:0]  rb_ff;
   logic                       hit_ff;
   logic [bbc_pkg::CMD_W-1:0]  dcmd_ff;
   logic [BW-1:0]              dblk_ff;
   logic [bbc_pkg::ERR_W-1:0]  err_ff;
   logic                       last_ff;

   function automatic logic [bbc_pkg::IDX_W-1:0] buf_code(input logic [IW-1:0] b);
      logic [XW-1:0] x;
      x = XW'(b);
      return x[bbc_pkg::IDX_W-1:0];
   endfunction

   logic [XW-1:0] idx_x;
   logic          in_range, scan_match, scan_end, out_free;
   logic [NW-1:0] nm1;
   logic [IW-1:0] idx_addr;

   assign idx_x      = XW'(idx_ff);
   assign in_range   = idx_x < XW'(NUM_BUFFERS);
   assign idx_addr   = idx_x[IW-1:0];
   assign scan_match = pend_ff && meta_q_ff.valid && (meta_q_ff.tag == cur_blk_ff);
   assign scan_end   = pend_ff && (pend_idx_ff == IW'(NUM_BUFFERS - 1));
   assign nm1        = n_ff - NW'(1);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // memory write and list update
   logic              meta_we, nx_we, pv_we, push_h, push_t;
   logic [IW-1:0]     meta_wa, nx_wa, nx_wd, pv_wa, pv_wd, push_b;
   bbc_pkg::meta_type meta_wd;

   always_comb begin
      meta_we  = 1'b0;
      meta_wa  = buf_ff;
      meta_wd  = meta_ff;
      nx_we    = 1'b0;
      nx_wa    = buf_ff;
      nx_wd    = buf_ff;
      pv_we    = 1'b0;
      pv_wa    = buf_ff;
      pv_wd    = buf_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      push_h   = 1'b0;
      push_t   = 1'b0;
      push_b   = buf_ff;
      unique case (cmd.op)
         bbc_pkg::OP_CLR: begin
            meta_we = 1'b1;
            meta_wa = clr_ff;
            meta_wd = '0;
            nx_we   = 1'b1;
            nx_wa   = clr_ff;
            nx_wd   = clr_ff + IW'(1);
            pv_we   = 1'b1;
            pv_wa   = clr_ff;
            pv_wd   = clr_ff - IW'(1);
         end
         bbc_pkg::OP_UNLINK: begin
            if (buf_ff != head_ff) begin
               nx_we = 1'b1;
               nx_wa = lprev_q_ff;
               nx_wd = lnext_q_ff;
            end else begin
               head_in = lnext_q_ff;
            end
            if (buf_ff != tail_ff) begin
               pv_we = 1'b1;
               pv_wa = lnext_q_ff;
               pv_wd = lprev_q_ff;
            end else begin
               tail_in = lprev_q_ff;
            end
            count_in = count_ff - CW'(1);
         end
         bbc_pkg::OP_USE: begin
            meta_we        = 1'b1;
            meta_wd.valid  = 1'b1;
            meta_wd.in_use = 1'b1;
            meta_wd.dirty  = (mode_ff == bbc_pkg::MODE_READ_AHEAD) ? 1'b0 : meta_ff.dirty;
         end
         bbc_pkg::OP_PUSHH_INV: begin
            meta_we = 1'b1;
            meta_wd = '0;
            push_h  = 1'b1;
         end
         bbc_pkg::OP_ALLOC: begin
            meta_we  = 1'b1;
            meta_wd  = '{valid: 1'b1, dirty: 1'b0, in_use: 1'b1, tag: cur_blk_ff};
            head_in  = lnext_q_ff;
            count_in = count_ff - CW'(1);
         end
         bbc_pkg::OP_RB: begin
            meta_we = 1'b1;
            meta_wa = bufs_ff[nm1[RAW-1:0]];
            meta_wd = old_ff[nm1[RAW-1:0]];
            push_h  = 1'b1;
            push_b  = bufs_ff[nm1[RAW-1:0]];
         end
         bbc_pkg::OP_RA_REL: begin
            meta_we = 1'b1;
            meta_wa = bufs_ff[r_ff[RAW-1:0]];
            meta_wd = '{valid: 1'b1, dirty: 1'b0, in_use: 1'b0,
                        tag: blks_ff[r_ff[RAW-1:0]]};
            push_t  = 1'b1;
            push_b  = bufs_ff[r_ff[RAW-1:0]];
         end
         bbc_pkg::OP_REL: begin
            meta_we        = 1'b1;
            meta_wd.dirty  = 1'b0;
            meta_wd.in_use = 1'b0;
            push_t         = 1'b1;
         end
         bbc_pkg::OP_DIRTY: begin
            meta_we       = 1'b1;
            meta_wd.dirty = 1'b1;
         end
         default: begin
         end
      endcase
      if (push_h) begin
         if (count_ff == '0) begin
            head_in = push_b;
            tail_in = push_b;
         end else begin
            pv_we   = 1'b1;
            pv_wa   = head_ff;
            pv_wd   = push_b;
            nx_we   = 1'b1;
            nx_wa   = push_b;
            nx_wd   = head_ff;
            head_in = push_b;
         end
         count_in = count_ff + CW'(1);
      end
      if (push_t) begin
         if (count_ff == '0) begin
            head_in = push_b;
            tail_in = push_b;
         end else begin
            nx_we   = 1'b1;
            nx_wa   = tail_ff;
            nx_wd   = push_b;
            pv_we   = 1'b1;
            pv_wa   = push_b;
            pv_wd   = tail_ff;
            tail_in = push_b;
         end
         count_in = count_ff + CW'(1);
      end
   end

   // memory reads
   logic          meta_re, link_re;
   logic [IW-1:0] meta_ra, link_ra;

   always_comb begin
      meta_re = 1'b0;
      meta_ra = head_ff;
      link_re = 1'b0;
      link_ra = head_ff;
      unique case (cmd.op)
         bbc_pkg::OP_SCAN: begin
            meta_re = !done_ff && !scan_match && !scan_end;
            meta_ra = scan_cnt_ff[IW-1:0];
         end
         bbc_pkg::OP_POP_RD: begin
            meta_re = 1'b1;
            link_re = 1'b1;
         end
         bbc_pkg::OP_LNK_RD: begin
            link_re = 1'b1;
            link_ra = buf_ff;
         end
         bbc_pkg::OP_RD_IDX: begin
            meta_re = in_range;
            meta_ra = idx_addr;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
      if (nx_we) next_mem[nx_wa] <= nx_wd;
      if (pv_we) prev_mem[pv_wa] <= pv_wd;
      if (meta_re) meta_q_ff <= meta_mem[meta_ra];
      if (link_re) begin
         lnext_q_ff <= next_mem[link_ra];
         lprev_q_ff <= prev_mem[link_ra];
      end
   end

   // list pointers, config, clear counter
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= IW'(NUM_BUFFERS - 1);
         count_ff <= CW'(NUM_BUFFERS);
         clr_ff   <= '0;
         cfg_ff   <= bbc_pkg::CFG_W'(1);
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (cmd.op == bbc_pkg::OP_CLR) clr_ff <= clr_ff + IW'(1);
         if (csr_write_enable) cfg_ff <= csr_write_data;
      end
   end

   // item, scan and read-ahead registers
   logic [NW-1:0] cfg_clamp;
   always_comb begin
      if (cfg_ff == '0) cfg_clamp = NW'(1);
      else if (cfg_ff > bbc_pkg::CFG_W'(MAX_READ_AHEAD)) cfg_clamp = NW'(MAX_READ_AHEAD);
      else cfg_clamp = cfg_ff[NW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
         n_ff     <= '0;
         t_ff     <= '0;
         e_ff     <= '0;
         r_ff     <= '0;
      end else begin
         unique case (cmd.op)
            bbc_pkg::OP_LOAD: begin
               mode_ff     <= req_mode;
               blk_ff      <= req_block_number;
               cur_blk_ff  <= req_block_number;
               idx_ff      <= req_buffer_index;
               total_ff    <= cfg_clamp;
               n_ff        <= '0;
               t_ff        <= '0;
               e_ff        <= '0;
               r_ff        <= NW'(1);
               scan_cnt_ff <= '0;
               pend_ff     <= 1'b0;
               done_ff     <= 1'b0;
               found_ff    <= 1'b0;
            end
            bbc_pkg::OP_NEXT_T: begin
               t_ff        <= t_ff + NW'(1);
               cur_blk_ff  <= cur_blk_ff + BW'(1);
               scan_cnt_ff <= '0;
               pend_ff     <= 1'b0;
               done_ff     <= 1'b0;
               found_ff    <= 1'b0;
            end
            bbc_pkg::OP_SCAN: begin
               if (done_ff) begin
               end else if (scan_match) begin
                  found_ff <= 1'b1;
                  done_ff  <= 1'b1;
                  pend_ff  <= 1'b0;
                  buf_ff   <= pend_idx_ff;
                  meta_ff  <= meta_q_ff;
               end else if (scan_end) begin
                  done_ff <= 1'b1;
                  pend_ff <= 1'b0;
               end else begin
                  pend_ff     <= 1'b1;
                  pend_idx_ff <= scan_cnt_ff[IW-1:0];
                  scan_cnt_ff <= scan_cnt_ff + CW'(1);
               end
            end
            bbc_pkg::OP_POP_RD: buf_ff <= head_ff;
            bbc_pkg::OP_ALLOC: begin
               if (mode_ff == bbc_pkg::MODE_READ_AHEAD) begin
                  bufs_ff[n_ff[RAW-1:0]] <= buf_ff;
                  blks_ff[n_ff[RAW-1:0]] <= cur_blk_ff;
                  old_ff[n_ff[RAW-1:0]]  <= meta_q_ff;
                  n_ff                   <= n_ff + NW'(1);
               end
            end
            bbc_pkg::OP_RB: n_ff <= nm1;
            bbc_pkg::OP_RA_REL: r_ff <= r_ff + NW'(1);
            bbc_pkg::OP_RD_IDX: buf_ff <= idx_addr;
            bbc_pkg::OP_CAP: meta_ff <= meta_q_ff;
            default: begin
            end
         endcase
         if (cmd.emit_en && cmd.kind == bbc_pkg::EK_RA) e_ff <= e_ff + NW'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_en) begin
         rb_ff   <= '0;
         hit_ff  <= 1'b0;
         dcmd_ff <= bbc_pkg::DEV_NONE;
         dblk_ff <= '0;
         err_ff  <= bbc_pkg::ERR_OK;
         last_ff <= 1'b1;
         unique case (cmd.kind)
            bbc_pkg::EK_HIT_BUSY: begin
               rb_ff  <= buf_code(buf_ff);
               hit_ff <= 1'b1;
               err_ff <= bbc_pkg::ERR_BUSY;
            end
            bbc_pkg::EK_HIT: begin
               rb_ff  <= buf_code(buf_ff);
               hit_ff <= 1'b1;
            end
            bbc_pkg::EK_MISS: begin
               rb_ff <= buf_code(buf_ff);
               if (mode_ff == bbc_pkg::MODE_GET_READ) begin
                  dcmd_ff <= bbc_pkg::DEV_READ;
                  dblk_ff <= blk_ff;
               end else if (mode_ff == bbc_pkg::MODE_GET_CLEAR) begin
                  dcmd_ff <= bbc_pkg::DEV_CLEAR;
                  dblk_ff <= blk_ff;
               end
            end
            bbc_pkg::EK_NO_FREE: err_ff <= bbc_pkg::ERR_NO_FREE;
            bbc_pkg::EK_REL_BAD: begin
               rb_ff  <= idx_ff;
               err_ff <= bbc_pkg::ERR_NOT_USE;
            end
            bbc_pkg::EK_REL_WB: begin
               rb_ff   <= idx_ff;
               dcmd_ff <= bbc_pkg::DEV_WRITE;
               dblk_ff <= meta_ff.tag;
            end
            bbc_pkg::EK_IDX: rb_ff <= idx_ff;
            bbc_pkg::EK_RA: begin
               rb_ff   <= buf_code(bufs_ff[e_ff[RAW-1:0]]);
               dcmd_ff <= bbc_pkg::DEV_READ;
               dblk_ff <= blks_ff[e_ff[RAW-1:0]];
               last_ff <= (e_ff == nm1);
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_buffer  = rb_ff;
   assign rsp_was_hit        = hit_ff;
   assign rsp_device_command = dcmd_ff;
   assign rsp_device_block   = dblk_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_last           = last_ff;

   always_comb begin
      status.mode         = mode_ff;
      status.clr_last     = (clr_ff == IW'(NUM_BUFFERS - 1));
      status.scan_done    = done_ff;
      status.found        = found_ff;
      status.meta_in_use  = meta_ff.in_use;
      status.meta_dirty   = meta_ff.dirty;
      status.idx_in_range = in_range;
      status.count_zero   = (count_ff == '0);
      status.t_first      = (t_ff == '0);
      status.t_last       = (t_ff == total_ff - NW'(1));
      status.n_zero       = (n_ff == '0);
      status.ra_emit_last = (e_ff == nm1);
      status.ra_rel_done  = (r_ff >= n_ff);
      status.out_free     = out_free;
   end

`ifndef ASSERT_OFF
   a_alloc_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bbc_pkg::OP_ALLOC |-> count_ff != '0)
      else $error("allocation from an empty free list");
   a_unlink_count: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bbc_pkg::OP_UNLINK |=> count_ff == $past(count_ff) - CW'(1))
      else $error("unlink did not shorten the free list");
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_en |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");
   a_rb_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bbc_pkg::OP_RB |-> n_ff != '0)
      else $error("rollback with no allocation recorded");
`endif

endmodule

@@ sv/bbc_ctrl.sv @@
// Controller: state machine that sequences datapath operations for each item.
`timescale 1ns / 1ps

module bbc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bbc_pkg::dp_status_type  status,
   output bbc_pkg::dp_cmd_type     cmd
);

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_DISPATCH = 5'd2;
   localparam logic [4:0] S_SCAN     = 5'd3;
   localparam logic [4:0] S_LNK_RD   = 5'd4;
   localparam logic [4:0] S_UNLINK   = 5'd5;
   localparam logic [4:0] S_USE      = 5'd6;
   localparam logic [4:0] S_PUSHH    = 5'd7;
   localparam logic [4:0] S_POP_RD   = 5'd8;
   localparam logic [4:0] S_ALLOC    = 5'd9;
   localparam logic [4:0] S_STEP     = 5'd10;
   localparam logic [4:0] S_RB       = 5'd11;
   localparam logic [4:0] S_RA_REL   = 5'd12;
   localparam logic [4:0] S_RA_EMIT  = 5'd13;
   localparam logic [4:0] S_RD_IDX   = 5'd14;
   localparam logic [4:0] S_CAP      = 5'd15;
   localparam logic [4:0] S_REL_DEC  = 5'd16;
   localparam logic [4:0] S_MARK_DEC = 5'd17;
   localparam logic [4:0] S_EMIT1    = 5'd18;

   logic [4:0]                  state_ff, state_in;
   bbc_pkg::emit_kind_type      kind_ff, kind_in;
   logic                        is_get, is_ra, is_inval;

   assign is_get   = status.mode <= bbc_pkg::MODE_GET_CLEAR;
   assign is_ra    = status.mode == bbc_pkg::MODE_READ_AHEAD;
   assign is_inval = status.mode == bbc_pkg::MODE_INVALIDATE;

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      cmd.op      = bbc_pkg::OP_NONE;
      cmd.emit_en = 1'b0;
      cmd.kind    = kind_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = bbc_pkg::OP_CLR;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = bbc_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (is_get || is_ra || is_inval) begin
               state_in = S_SCAN;
            end else if (status.mode == bbc_pkg::MODE_RELEASE ||
                         status.mode == bbc_pkg::MODE_MARK_DIRTY) begin
               state_in = S_RD_IDX;
            end else begin
               kind_in  = bbc_pkg::EK_ZERO;
               state_in = S_EMIT1;
            end
         end
         S_SCAN: begin
            if (!status.scan_done) begin
               cmd.op = bbc_pkg::OP_SCAN;
            end else if (is_inval) begin
               if (!status.found) begin
                  kind_in  = bbc_pkg::EK_ZERO;
                  state_in = S_EMIT1;
               end else if (status.meta_in_use) begin
                  state_in = S_PUSHH;
               end else begin
                  state_in = S_LNK_RD;
               end
            end else if (status.found && (is_get || status.t_first)) begin
               if (status.meta_in_use) begin
                  kind_in  = bbc_pkg::EK_HIT_BUSY;
                  state_in = S_EMIT1;
               end else begin
                  state_in = S_LNK_RD;
               end
            end else if (status.found) begin
               state_in = S_STEP;
            end else if (status.count_zero) begin
               kind_in  = bbc_pkg::EK_NO_FREE;
               state_in = is_ra ? S_RB : S_EMIT1;
            end else begin
               state_in = S_POP_RD;
            end
         end
         S_LNK_RD: begin
            cmd.op   = bbc_pkg::OP_LNK_RD;
            state_in = S_UNLINK;
         end
         S_UNLINK: begin
            cmd.op   = bbc_pkg::OP_UNLINK;
            state_in = is_inval ? S_PUSHH : S_USE;
         end
         S_USE: begin
            cmd.op   = bbc_pkg::OP_USE;
            kind_in  = bbc_pkg::EK_HIT;
            state_in = S_EMIT1;
         end
         S_PUSHH: begin
            cmd.op   = bbc_pkg::OP_PUSHH_INV;
            kind_in  = bbc_pkg::EK_HIT;
            state_in = S_EMIT1;
         end
         S_POP_RD: begin
            cmd.op   = bbc_pkg::OP_POP_RD;
            state_in = S_ALLOC;
         end
         S_ALLOC: begin
            cmd.op = bbc_pkg::OP_ALLOC;
            if (is_ra) begin
               state_in = S_STEP;
            end else begin
               kind_in  = bbc_pkg::EK_MISS;
               state_in = S_EMIT1;
            end
         end
         S_STEP: begin
            if (status.t_last) begin
               state_in = S_RA_REL;
            end else begin
               cmd.op   = bbc_pkg::OP_NEXT_T;
               state_in = S_SCAN;
            end
         end
         S_RB: begin
            // undo the allocations of a read-ahead that ran dry
            if (status.n_zero) state_in = S_EMIT1;
            else cmd.op = bbc_pkg::OP_RB;
         end
         S_RA_REL: begin
            if (status.ra_rel_done) state_in = S_RA_EMIT;
            else cmd.op = bbc_pkg::OP_RA_REL;
         end
         S_RA_EMIT: begin
            cmd.kind = bbc_pkg::EK_RA;
            if (status.out_free) begin
               cmd.emit_en = 1'b1;
               if (status.ra_emit_last) state_in = S_IDLE;
            end
         end
         S_RD_IDX: begin
            cmd.op   = bbc_pkg::OP_RD_IDX;
            state_in = S_CAP;
         end
         S_CAP: begin
            cmd.op   = bbc_pkg::OP_CAP;
            state_in = (status.mode == bbc_pkg::MODE_RELEASE) ? S_REL_DEC : S_MARK_DEC;
         end
         S_REL_DEC: begin
            if (!status.idx_in_range || !status.meta_in_use) begin
               kind_in = bbc_pkg::EK_REL_BAD;
            end else begin
               cmd.op  = bbc_pkg::OP_REL;
               kind_in = status.meta_dirty ? bbc_pkg::EK_REL_WB : bbc_pkg::EK_IDX;
            end
            state_in = S_EMIT1;
         end
         S_MARK_DEC: begin
            if (status.idx_in_range && status.meta_in_use) cmd.op = bbc_pkg::OP_DIRTY;
            kind_in  = bbc_pkg::EK_IDX;
            state_in = S_EMIT1;
         end
         S_EMIT1: begin
            if (status.out_free) begin
               cmd.emit_en = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         kind_ff  <= bbc_pkg::EK_ZERO;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule
